FILE: design/ctwnd_pkg.sv
`timescale 1ns / 1ps
package ctwnd_pkg;

  // Register-field widths
  localparam int unsigned POS_W  = 32;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned FLEN_W = 24;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STEP_W = 4;

  localparam logic [WIN_W-1:0] WINDOW_MAX = 16'hFFFF;
  localparam logic [WIN_W-1:0] MSS_FLOOR  = 16'd1024;
  localparam logic [WIN_W-1:0] CWND_RESET = 16'd1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FILE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SEGMENT_SIZE = 2'd1;
  localparam logic [1:0] REG_SS_LIMIT     = 2'd2;

  typedef enum logic [1:0] {EM_NONE, EM_DATA, EM_FIN, EM_ERR} emit_t;
  typedef enum logic [2:0] {OP_NONE, OP_LOAD, OP_TAIL, OP_GROW, OP_PIECE, OP_COMMIT} op_t;
  typedef enum logic [2:0] {JC_NONE, JC_ALWAYS, JC_RANGE, JC_TAIL, JC_MORE} jcond_t;
  typedef enum logic [1:0] {LM_NO, LM_YES, LM_FITS} lastm_t;

  // One microcode word
  typedef struct packed {
    logic              accept;
    emit_t             emit;
    logic              whole;
    lastm_t            lastm;
    op_t               op;
    jcond_t            jc;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Datapath status feeding the jump logic
  typedef struct packed {
    logic range_err;
    logic tail;
    logic more;
  } flags_t;

  // Step addresses
  localparam logic [STEP_W-1:0] S_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] S_CHECK    = 4'd1;
  localparam logic [STEP_W-1:0] S_TAILCHK  = 4'd2;
  localparam logic [STEP_W-1:0] S_GROW     = 4'd3;
  localparam logic [STEP_W-1:0] S_PIECE    = 4'd4;
  localparam logic [STEP_W-1:0] S_COMMIT   = 4'd5;
  localparam logic [STEP_W-1:0] S_TAIL     = 4'd6;
  localparam logic [STEP_W-1:0] S_TGROW    = 4'd7;
  localparam logic [STEP_W-1:0] S_TDATA    = 4'd8;
  localparam logic [STEP_W-1:0] S_FIN      = 4'd9;
  localparam logic [STEP_W-1:0] S_ERR_GROW = 4'd10;
  localparam logic [STEP_W-1:0] S_ERR      = 4'd11;

  function automatic ctrl_t uword(logic acc, emit_t em, logic wh, lastm_t lm, op_t op,
                                  jcond_t jc, logic [STEP_W-1:0] tgt);
    ctrl_t c;
    c.accept = acc;
    c.emit   = em;
    c.whole  = wh;
    c.lastm  = lm;
    c.op     = op;
    c.jc     = jc;
    c.target = tgt;
    return c;
  endfunction

  // Control store
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      S_WAIT:     c = uword(1'b1, EM_NONE, 1'b0, LM_NO,   OP_LOAD,   JC_NONE,   S_WAIT);
      S_CHECK:    c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_NONE,   JC_RANGE,  S_ERR_GROW);
      S_TAILCHK:  c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_NONE,   JC_TAIL,   S_TAIL);
      S_GROW:     c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_GROW,   JC_NONE,   S_WAIT);
      S_PIECE:    c = uword(1'b0, EM_DATA, 1'b0, LM_FITS, OP_PIECE,  JC_MORE,   S_PIECE);
      S_COMMIT:   c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_COMMIT, JC_ALWAYS, S_WAIT);
      S_TAIL:     c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_TAIL,   JC_NONE,   S_WAIT);
      S_TGROW:    c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_GROW,   JC_NONE,   S_WAIT);
      S_TDATA:    c = uword(1'b0, EM_DATA, 1'b1, LM_NO,   OP_NONE,   JC_NONE,   S_WAIT);
      S_FIN:      c = uword(1'b0, EM_FIN,  1'b0, LM_YES,  OP_NONE,   JC_ALWAYS, S_COMMIT);
      S_ERR_GROW: c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_GROW,   JC_NONE,   S_WAIT);
      S_ERR:      c = uword(1'b0, EM_ERR,  1'b0, LM_YES,  OP_NONE,   JC_ALWAYS, S_COMMIT);
      default:    c = uword(1'b0, EM_NONE, 1'b0, LM_NO,   OP_NONE,   JC_ALWAYS, S_WAIT);
    endcase
    return c;
  endfunction

endpackage

FILE: design/ctwnd_seq.sv
`timescale 1ns / 1ps
module ctwnd_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_free,
  input  ctwnd_pkg::flags_t flags,
  output ctwnd_pkg::ctrl_t  ctrl,
  output logic            go
);
  import ctwnd_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              jump;

  // Fetch the current control word
  assign ctrl = ucode(pc);

  // A step finishes once its input and output sides are ready
  assign go = (!ctrl.accept || in_valid) && ((ctrl.emit == EM_NONE) || out_free);

  // Jump condition select
  always_comb begin
    case (ctrl.jc)
      JC_NONE:   jump = 1'b0;
      JC_ALWAYS: jump = 1'b1;
      JC_RANGE:  jump = flags.range_err;
      JC_TAIL:   jump = flags.tail;
      JC_MORE:   jump = flags.more;
      default:   jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      pc_next = jump ? ctrl.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Input side only opens in the wait step, and closes right after a transaction
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.accept && in_valid) |=> !ctrl.accept)
    else $error("sequencer stayed in wait step after a transaction");

  // A piece that is not the last must loop back to the piece step
  assert property (@(posedge clk) disable iff (rst)
    (pc == S_PIECE && go && flags.more) |=> (pc == S_PIECE))
    else $error("piece loop exited early");

  // A fin or error result is always followed by the commit step
  assert property (@(posedge clk) disable iff (rst)
    (go && (ctrl.emit == EM_FIN || ctrl.emit == EM_ERR)) |=> (pc == S_COMMIT))
    else $error("final result not followed by commit");

endmodule

FILE: design/ctwnd_dp.sv
`timescale 1ns / 1ps
module ctwnd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ctwnd_pkg::ctrl_t                    ctrl,
  input  logic                                go,
  input  logic [ctwnd_pkg::POS_W-1:0]         ack_position,
  input  logic [ctwnd_pkg::POS_W-1:0]         peer_sequence,
  input  logic [ctwnd_pkg::WIN_W-1:0]         peer_window,
  input  logic [ctwnd_pkg::FLEN_W-1:0]        file_length,
  input  logic [ctwnd_pkg::WIN_W-1:0]         mss,
  input  logic [ctwnd_pkg::WIN_W-1:0]         slow_start_limit,
  input  logic                                out_stall,
  output ctwnd_pkg::flags_t                   flags,
  output logic                                out_free,
  output logic                                out_valid,
  output logic [ctwnd_pkg::KIND_W-1:0]        kind,
  output logic [ctwnd_pkg::POS_W-1:0]         segment_start,
  output logic [ctwnd_pkg::POS_W-1:0]         segment_ack,
  output logic [ctwnd_pkg::WIN_W-1:0]         segment_length,
  output logic                                last,
  output logic [ctwnd_pkg::WIN_W-1:0]         window_now
);
  import ctwnd_pkg::*;

  // Working registers
  logic [POS_W-1:0] start;
  logic [POS_W-1:0] ack;
  logic [WIN_W-1:0] rem;
  logic [WIN_W-1:0] pwin;
  logic [WIN_W-1:0] nwin;
  logic [WIN_W-1:0] cwnd;

  logic [WIN_W-1:0] len_piece;
  logic [WIN_W-1:0] len_out;
  logic [WIN_W:0]   grow_sum;
  logic [WIN_W-1:0] grown;
  logic [WIN_W-1:0] clamped;
  logic [POS_W:0]   reach;
  logic [POS_W-1:0] to_end;
  logic             last_now;

  // Status for the jump logic
  assign reach = {1'b0, start} + {{(POS_W+1-WIN_W){1'b0}}, rem};
  assign flags.range_err = (start == '0) || (start > {{(POS_W-FLEN_W){1'b0}}, file_length});
  assign flags.tail      = {{(POS_W+1-FLEN_W){1'b0}}, file_length} < reach;
  assign flags.more      = rem > mss;

  assign to_end    = {{(POS_W-FLEN_W){1'b0}}, file_length} - start;
  assign len_piece = flags.more ? mss : rem;
  assign len_out   = ctrl.whole ? rem : len_piece;

  // Window growth: additive at or above the limit, doubling below, then clamp
  assign grow_sum = {1'b0, rem} + {1'b0, mss};
  always_comb begin
    if (rem >= slow_start_limit) begin
      grown = grow_sum[WIN_W] ? WINDOW_MAX : grow_sum[WIN_W-1:0];
    end else begin
      grown = rem[WIN_W-1] ? WINDOW_MAX : {rem[WIN_W-2:0], 1'b0};
    end
    clamped = (grown > pwin) ? pwin : grown;
  end

  always_comb begin
    case (ctrl.lastm)
      LM_NO:   last_now = 1'b0;
      LM_YES:  last_now = 1'b1;
      LM_FITS: last_now = !flags.more;
      default: last_now = 1'b0;
    endcase
  end

  assign out_free = !out_valid || !out_stall;

  // Datapath operations
  always_ff @(posedge clk) begin
    if (go) begin
      case (ctrl.op)
        OP_LOAD: begin
          start <= ack_position;
          ack   <= peer_sequence;
          pwin  <= peer_window;
          rem   <= cwnd;
        end
        OP_TAIL: begin
          rem   <= to_end[WIN_W-1:0];
          start <= start - 1'b1;
          ack   <= '0;
        end
        OP_GROW: begin
          nwin <= clamped;
        end
        OP_PIECE: begin
          start <= start + {{(POS_W-WIN_W){1'b0}}, len_piece};
          rem   <= rem - len_piece;
          ack   <= ack + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Congestion window state
  always_ff @(posedge clk) begin
    if (rst) begin
      cwnd <= CWND_RESET;
    end else if (go && ctrl.op == OP_COMMIT) begin
      cwnd <= nwin;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && ctrl.emit != EM_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.emit != EM_NONE) begin
      case (ctrl.emit)
        EM_DATA: kind <= KIND_DATA;
        EM_FIN:  kind <= KIND_FIN;
        default: kind <= KIND_ERR;
      endcase
      segment_start  <= (ctrl.emit == EM_DATA) ? start : '0;
      segment_ack    <= (ctrl.emit == EM_DATA) ? ack : '0;
      segment_length <= (ctrl.emit == EM_DATA) ? len_out : '0;
      last           <= last_now;
      window_now     <= last_now ? nwin : '0;
    end
  end

  // Window never exceeds the peer window after a commit
  assert property (@(posedge clk) disable iff (rst)
    (go && ctrl.op == OP_COMMIT) |=> (cwnd <= pwin))
    else $error("congestion window above peer window");

  // Only the final result carries a window value
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (window_now == '0))
    else $error("window reported on a non-final result");

  // Error and fin results always end the transaction group
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_ERR || kind == KIND_FIN)) |-> last)
    else $error("error or fin result not marked last");

endmodule

FILE: design/tcp_congestion_window_sender_top.sv
`timescale 1ns / 1ps
// TCP sender congestion window, slow start and congestion avoidance.
// Input channel (in_valid / in_stall): one acknowledgment per transaction with
// ack_position, peer_sequence and peer_window. Output channel (out_valid /
// out_stall): segment descriptors with kind, segment_start, segment_ack,
// segment_length, last and window_now; window_now is nonzero only with last.
// Config channel (cfg_valid / cfg_ready): cfg_index 0 file_length, 1
// segment_size, 2 slow_start_limit; other indexes are ignored. cfg_ready is
// always high; write only while idle.
// Timing: a microcoded sequencer steps through a small control store, one step
// per cycle unless a step waits for input or for the output register. After
// acceptance it checks range and tail, grows the window, emits its pieces and
// commits; a tail request trims, grows, emits data and fin, then commits; an
// out-of-range request grows, emits an error and commits. The next ack can be
// taken in the cycle after commit, so acknowledgments never overlap.
// Output stall: the step that emits a result waits while the output register
// is full and stalled; nothing is lost or reordered.
// Reset (rst, synchronous): window 1, segment_size 1024, slow_start_limit
// 65535, file_length 0, output empty, sequencer in its wait step.
module tcp_congestion_window_sender_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ctwnd_pkg::FLEN_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ctwnd_pkg::POS_W-1:0]   ack_position,
  input  logic [ctwnd_pkg::POS_W-1:0]   peer_sequence,
  input  logic [ctwnd_pkg::WIN_W-1:0]   peer_window,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ctwnd_pkg::KIND_W-1:0]  kind,
  output logic [ctwnd_pkg::POS_W-1:0]   segment_start,
  output logic [ctwnd_pkg::POS_W-1:0]   segment_ack,
  output logic [ctwnd_pkg::WIN_W-1:0]   segment_length,
  output logic                          last,
  output logic [ctwnd_pkg::WIN_W-1:0]   window_now
);
  import ctwnd_pkg::*;

  logic [FLEN_W-1:0] file_length;
  logic [WIN_W-1:0]  segment_size;
  logic [WIN_W-1:0]  slow_start_limit;
  logic [WIN_W-1:0]  mss;
  ctrl_t             ctrl;
  flags_t            flags;
  logic              go;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ctrl.accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length      <= '0;
      segment_size     <= MSS_FLOOR;
      slow_start_limit <= WINDOW_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILE_LENGTH:  file_length      <= cfg_data;
        REG_SEGMENT_SIZE: segment_size     <= cfg_data[WIN_W-1:0];
        REG_SS_LIMIT:     slow_start_limit <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Segment sizes below the floor are raised to it
  assign mss = (segment_size < MSS_FLOOR) ? MSS_FLOOR : segment_size;

  ctwnd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .go       (go)
  );

  ctwnd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .go               (go),
    .ack_position     (ack_position),
    .peer_sequence    (peer_sequence),
    .peer_window      (peer_window),
    .file_length      (file_length),
    .mss              (mss),
    .slow_start_limit (slow_start_limit),
    .out_stall        (out_stall),
    .flags            (flags),
    .out_free         (out_free),
    .out_valid        (out_valid),
    .kind             (kind),
    .segment_start    (segment_start),
    .segment_ack      (segment_ack),
    .segment_length   (segment_length),
    .last             (last),
    .window_now       (window_now)
  );

endmodule

FILE: tb/cwnd_segment_checker.sv
`timescale 1ns / 1ps
module cwnd_segment_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [ctwnd_pkg::FLEN_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [ctwnd_pkg::POS_W-1:0]  ack_position,
  input  logic [ctwnd_pkg::POS_W-1:0]  peer_sequence,
  input  logic [ctwnd_pkg::WIN_W-1:0]  peer_window,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [ctwnd_pkg::KIND_W-1:0] kind,
  input  logic [ctwnd_pkg::POS_W-1:0]  segment_start,
  input  logic [ctwnd_pkg::POS_W-1:0]  segment_ack,
  input  logic [ctwnd_pkg::WIN_W-1:0]  segment_length,
  input  logic                         last,
  input  logic [ctwnd_pkg::WIN_W-1:0]  window_now,
  output int                           mismatches,
  output int                           outstanding,
  output int                           segments_seen
);
  import ctwnd_pkg::*;

  localparam int REPORT_LIMIT = 40;

  // One segment descriptor as it should leave the block
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  ack;
    logic [WIN_W-1:0]  len;
    logic              last;
    logic [WIN_W-1:0]  win;
  } segment_t;

  segment_t          due_segments[$];
  segment_t          burst[64];
  int                burst_len;
  logic [FLEN_W-1:0] file_len;
  logic [WIN_W-1:0]  mss_reg;
  logic [WIN_W-1:0]  ss_limit;
  logic [WIN_W-1:0]  cwnd;
  int                err_count  = 0;
  int                seen_count = 0;

  function automatic void add_segment(logic [KIND_W-1:0] k, logic [POS_W-1:0] s,
                                      logic [POS_W-1:0] a, logic [WIN_W-1:0] l);
    burst[burst_len] = '{kind: k, start: s, ack: a, len: l, last: 1'b0, win: '0};
    burst_len++;
  endfunction

  // Segments caused by one acknowledgment, then the window update
  function automatic void predict_segments(logic [POS_W-1:0] pos, logic [POS_W-1:0] seq,
                                           logic [WIN_W-1:0] pwin);
    logic [WIN_W-1:0] mss;
    logic [16:0]      w;
    logic [16:0]      sent;
    logic [16:0]      chunk;
    logic [POS_W-1:0] gap;
    logic [POS_W-1:0] piece;
    mss = (mss_reg < MSS_FLOOR) ? MSS_FLOOR : mss_reg;
    w = {1'b0, cwnd};
    burst_len = 0;
    if (pos == '0 || pos > {8'd0, file_len}) begin
      add_segment(KIND_ERR, '0, '0, '0);
    end else if ({9'd0, file_len} < {1'b0, pos} + {16'd0, w}) begin
      // tail: what is left of the file, then a fin
      gap = {8'd0, file_len} - pos;
      w = {1'b0, gap[WIN_W-1:0]};
      add_segment(KIND_DATA, pos - 1, '0, w[WIN_W-1:0]);
      add_segment(KIND_FIN, '0, '0, '0);
    end else if (w <= {1'b0, mss}) begin
      add_segment(KIND_DATA, pos, seq, w[WIN_W-1:0]);
    end else begin
      // mss pieces, the last one at most mss, ack rising by one per piece
      sent = '0;
      piece = '0;
      while (sent < w) begin
        chunk = w - sent;
        if (chunk > {1'b0, mss}) chunk = {1'b0, mss};
        add_segment(KIND_DATA, pos + {15'd0, sent}, seq + piece, chunk[WIN_W-1:0]);
        piece++;
        sent = sent + chunk;
      end
    end
    // growth: doubling below the limit, additive at or above it
    if (w >= {1'b0, ss_limit}) w = w + {1'b0, mss};
    else w = w << 1;
    if (w > {1'b0, WINDOW_MAX}) w = {1'b0, WINDOW_MAX};
    if (w > {1'b0, pwin}) w = {1'b0, pwin};
    cwnd = w[WIN_W-1:0];
    burst[burst_len-1].last = 1'b1;
    burst[burst_len-1].win = cwnd;
    for (int i = 0; i < burst_len; i++) due_segments.push_back(burst[i]);
  endfunction

  function automatic void check_field(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= REPORT_LIMIT)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    segment_t want;
    if (rst) begin
      file_len = '0;
      mss_reg  = MSS_FLOOR;
      ss_limit = WINDOW_MAX;
      cwnd     = CWND_RESET;
      due_segments.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILE_LENGTH:  file_len = cfg_data;
          REG_SEGMENT_SIZE: mss_reg  = cfg_data[WIN_W-1:0];
          REG_SS_LIMIT:     ss_limit = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      // acknowledgment transaction
      if (in_valid && !in_stall)
        predict_segments(ack_position, peer_sequence, peer_window);
      // segment transaction
      if (out_valid && !out_stall) begin
        seen_count++;
        if (due_segments.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("%0t: segment expected none actual kind %0d start %0h ack %0h len %0d",
                     $time, kind, segment_start, segment_ack, segment_length);
        end else begin
          want = due_segments.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("segment_start", want.start, segment_start);
          check_field("segment_ack", want.ack, segment_ack);
          check_field("segment_length", 32'(want.len), 32'(segment_length));
          check_field("last", 32'(want.last), 32'(last));
          check_field("window_now", 32'(want.win), 32'(window_now));
        end
      end
    end
    mismatches    <= err_count;
    outstanding   <= due_segments.size();
    segments_seen <= seen_count;
  end

endmodule

FILE: tb/tcp_congestion_window_sender_top_tb.sv
`timescale 1ns / 1ps
module tcp_congestion_window_sender_top_tb;
  import ctwnd_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // index with no register behind it
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index     = '0;
  logic [FLEN_W-1:0] cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [POS_W-1:0]  ack_position  = '0;
  logic [POS_W-1:0]  peer_sequence = '0;
  logic [WIN_W-1:0]  peer_window   = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  segment_start;
  logic [POS_W-1:0]  segment_ack;
  logic [WIN_W-1:0]  segment_length;
  logic              last;
  logic [WIN_W-1:0]  window_now;

  int mismatches;
  int outstanding;
  int segments_seen;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_ticket   = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int acks_sent     = 0;
  int settings_used = 0;

  logic [FLEN_W-1:0] cur_flen  = '0;
  logic [WIN_W-1:0]  cur_limit = WINDOW_MAX;
  logic [POS_W-1:0]  cursor    = 32'd1;

  tcp_congestion_window_sender_top u_top (.*);

  cwnd_segment_checker u_checker (.*);

  always #5 clk = ~clk;

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("tcp_congestion_window_sender_top verification failed");
    $finish;
  end

  // One acknowledgment transaction; valid stays high for a following item
  task automatic send_ack(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] seq,
                          input logic [WIN_W-1:0] pwin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    ack_position  <= pos;
    peer_sequence <= seq;
    peer_window   <= pwin;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    acks_sent++;
  endtask

  // Drop valid and wait until every predicted segment has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // let the commit step finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [FLEN_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper bits of the 16-bit registers carry junk the block must drop
  task automatic configure(input logic [FLEN_W-1:0] flen, input logic [WIN_W-1:0] mss,
                           input logic [WIN_W-1:0] limit);
    settle();
    write_reg(REG_FILE_LENGTH, flen);
    write_reg(REG_SEGMENT_SIZE, {8'($urandom), mss});
    write_reg(REG_SS_LIMIT, {8'($urandom), limit});
    write_reg(REG_SPARE, 24'($urandom));
    cfg_valid <= 1'b0;
    cur_flen  = flen;
    cur_limit = limit;
    cursor    = 32'd1;
    settings_used++;
  endtask

  // Mostly positions inside the file, walking forward or near the tail
  task automatic random_acks(input int count);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] seq;
    logic [WIN_W-1:0] pwin;
    int               pick;
    bit               zeros_ok;
    for (int i = 0; i < count; i++) begin
      // a zero window only recovers with additive growth; keep the phase end clean
      zeros_ok = (cur_limit == '0) && (i < count - 5);
      pick = $urandom_range(99);
      if (pick < 60) begin
        pos = cursor;
        cursor = cursor + $urandom_range(1, 6000);
        if (cursor > {8'd0, cur_flen}) cursor = 32'd1;
      end else if (pick < 75) begin
        if (cur_flen > 3001)
          pos = {8'd0, cur_flen} - $urandom_range(zeros_ok ? 0 : 1, 3000);
        else
          pos = 32'd1;
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0:       pos = '0;
          1:       pos = {8'd0, cur_flen} + 1;
          default: pos = {8'd0, cur_flen} + $urandom_range(2, 1 << 20);
        endcase
      end else begin
        pos = $urandom;
      end
      if ($urandom_range(9) < 2) seq = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else seq = $urandom;
      pick = $urandom_range(99);
      if (pick < 15) pwin = WINDOW_MAX;
      else if (pick < 30) pwin = 16'($urandom_range(1, 4000));
      else if (pick < 35) pwin = zeros_ok ? 16'd0 : 16'd1;
      else pwin = 16'($urandom_range(1, 65535));
      send_ack(pos, seq, pwin);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: out of range, growth to saturation, tail, zero window
    configure(24'd100000, 16'd1024, WINDOW_MAX);
    send_ack('0, 32'h1234_5678, WINDOW_MAX);
    send_ack(32'd100001, 32'h0000_0001, WINDOW_MAX);
    send_ack('1, '1, WINDOW_MAX);
    for (int k = 0; k < 14; k++) send_ack(32'(1 + k * 100), 32'hFFFF_FFF8, WINDOW_MAX);
    send_ack(32'd2000, '0, 16'h8000);
    send_ack(32'd99990, 32'h0000_0042, WINDOW_MAX);
    send_ack(32'd100000, 32'h8000_0000, WINDOW_MAX);
    send_ack(32'd5, 32'h5555_AAAA, 16'd0);

    // Random phases over several register settings and idle modes
    configure(24'd1_000_000, 16'd500, 16'd0);
    idle_pct = 0;
    stall_pct = 0;
    random_acks(50);

    configure(24'hFF_FFFF, WINDOW_MAX, 16'd1);
    idle_pct = 81;
    stall_pct = 0;
    random_acks(50);

    configure(24'd50000, 16'd1460, 16'd8000);
    idle_pct = 0;
    stall_pct = 81;
    random_acks(50);

    configure('0, '0, WINDOW_MAX);
    idle_pct = 21;
    stall_pct = 21;
    random_acks(15);

    // long output hold while acks keep coming, then a full drain mid-phase
    configure(24'd300000, 16'd4096, 16'd30000);
    idle_pct = 0;
    stall_pct = 0;
    hold_ticket++;
    random_acks(35);
    settle();
    random_acks(35);

    configure(24'd123457, 16'd1024, WINDOW_MAX);
    idle_pct = 21;
    stall_pct = 21;
    random_acks(60);

    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d acknowledgments over %0d register settings, %0d segments checked.",
             acks_sent, settings_used, segments_seen);
    $display("Idle modes: none, sender 81%%, receiver 81%%, both 21%%; one long hold, one drain.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tcp_congestion_window_sender_top verification clean");
    end else begin
      $display("tcp_congestion_window_sender_top verification failed");
    end
    $finish;
  end

endmodule
